[sv/chim_pkg.sv]
`default_nettype none

package chim_pkg;

  localparam int KEY_W       = 32;
  localparam int SLOT_W      = 10;
  localparam int BUCKET_W    = 11;
  localparam int NB_W        = 12;
  localparam int MAX_SLOTS   = 1024;
  localparam int MAX_BUCKETS = 2048;
  localparam int REM_DIGITS  = 4;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NF   = 2'd1;
  localparam logic [1:0] STAT_DUP  = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  localparam logic [NB_W-1:0] NB_RESET = 12'd2039;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } head_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    head_t            link;
  } slot_t;

  typedef struct packed {
    logic                rd;
    logic                wr;
    logic [BUCKET_W-1:0] addr;
    head_t               wdata;
  } head_req_t;

endpackage

`default_nettype wire

[sv/chim_rem.sv]
`default_nettype none

module chim_rem import chim_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [KEY_W-1:0]    key,
  input  wire logic [NB_W-1:0]     nb,
  output logic                     done,
  output logic [BUCKET_W-1:0]      rem
);

  localparam int STEPS = KEY_W / REM_DIGITS;
  localparam int CNT_W = $clog2(STEPS);

  logic                running;
  logic [CNT_W-1:0]    cnt;
  logic [BUCKET_W-1:0] r;
  logic [KEY_W-1:0]    k;
  logic [NB_W-1:0]     nbq;
  logic [BUCKET_W-1:0] r_next;
  logic [KEY_W-1:0]    k_next;
  logic [NB_W-1:0]     t;

  // four restoring remainder digits per cycle
  always_comb begin
    r_next = r;
    k_next = k;
    t = '0;
    for (int i = 0; i < REM_DIGITS; i++) begin
      t = {r_next, k_next[KEY_W-1]};
      k_next = {k_next[KEY_W-2:0], 1'b0};
      if (t >= nbq) begin
        t = t - nbq;
      end
      r_next = t[BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= '0;
      k   <= key;
      nbq <= nb;
    end else if (running) begin
      r <= r_next;
      k <= k_next;
    end
  end

  assign rem = r;

endmodule

`default_nettype wire

[sv/chim_heads.sv]
`default_nettype none

module chim_heads import chim_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      clr,
  input  wire head_req_t req,
  output head_t          rdata,
  output logic           clearing
);

  head_t               mem [MAX_BUCKETS];
  logic [BUCKET_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      clearing <= 1'b1;
      cnt      <= '0;
    end else if (clearing) begin
      cnt <= cnt + 1'b1;
      if (cnt == BUCKET_W'(MAX_BUCKETS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[cnt] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

[sv/chim_slots.sv]
`default_nettype none

module chim_slots import chim_pkg::*; (
  input  wire logic              clk,
  input  wire logic              wr,
  input  wire logic [SLOT_W-1:0] waddr,
  input  wire slot_t             wdata,
  input  wire logic              rd,
  input  wire logic [SLOT_W-1:0] raddr,
  output slot_t                  rdata
);

  slot_t mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[waddr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/chained_hash_index_map.sv]
// insert and lookup load the key, run the remainder, read the bucket head, read
// one slot per chain entry visited, and register the result
// throughput: one transaction at a time, busy stays high until done
// clear runs the bucket-head sweep of 2048 entries
// reset runs the same bucket-head sweep; busy is high throughout
// the receiver cannot stall: done is a single-cycle strobe
`default_nettype none

module chained_hash_index_map import chim_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        mode,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic              cfg_wr_en,
  input  wire logic [NB_W-1:0]   cfg_wr_data,
  output logic                   done,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [1:0]             status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_HASH = 3'd2;
  localparam logic [2:0] ST_HCHK = 3'd3;
  localparam logic [2:0] ST_SCHK = 3'd4;

  logic [2:0]          state;
  logic [1:0]          mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [BUCKET_W-1:0] bucket;
  logic [SLOT_W:0]     slot_count;
  logic [NB_W-1:0]     num_buckets;
  logic [NB_W-1:0]     nb_eff;

  logic                accept;
  logic                rem_done;
  logic [BUCKET_W-1:0] rem;
  logic                clearing;
  head_t               head_rdata;
  head_req_t           head_req;
  slot_t               slot_rdata;
  slot_t               slot_wdata;
  logic                slot_rd;
  logic [SLOT_W-1:0]   slot_raddr;
  logic                hit;
  logic                miss;
  logic                ins;
  logic                full;
  // slot whose entry is on the read port
  logic [SLOT_W-1:0]   slot_raddr_q;

  assign busy   = (state != ST_IDLE) || clearing;
  assign accept = start && !busy;
  assign full   = slot_count[SLOT_W];

  always_comb begin
    if (num_buckets == '0) begin
      nb_eff = NB_W'(1);
    end else if (num_buckets > NB_W'(MAX_BUCKETS)) begin
      nb_eff = NB_W'(MAX_BUCKETS);
    end else begin
      nb_eff = num_buckets;
    end
  end

  always_comb begin
    hit  = (state == ST_SCHK) && (slot_rdata.key == key_q);
    miss = ((state == ST_HCHK) && !head_rdata.valid) ||
           ((state == ST_SCHK) && (slot_rdata.key != key_q) && !slot_rdata.link.valid);
    ins  = miss && (mode_q == MODE_INSERT) && !full;
    slot_rd = ((state == ST_HCHK) && head_rdata.valid) ||
              ((state == ST_SCHK) && (slot_rdata.key != key_q) && slot_rdata.link.valid);
    slot_raddr = (state == ST_HCHK) ? head_rdata.slot : slot_rdata.link.slot;
    head_req.rd          = (state == ST_HASH) && rem_done;
    head_req.wr          = ins;
    head_req.addr        = (state == ST_HASH) ? rem : bucket;
    head_req.wdata.valid = 1'b1;
    head_req.wdata.slot  = slot_count[SLOT_W-1:0];
    slot_wdata.key       = key_q;
    slot_wdata.link      = head_rdata;
  end

  chim_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (accept && ((mode == MODE_INSERT) || (mode == MODE_LOOKUP))),
    .key   (key),
    .nb    (nb_eff),
    .done  (rem_done),
    .rem   (rem)
  );

  chim_heads u_heads (
    .clk      (clk),
    .rst      (rst),
    .clr      (accept && (mode == MODE_CLEAR)),
    .req      (head_req),
    .rdata    (head_rdata),
    .clearing (clearing)
  );

  chim_slots u_slots (
    .clk   (clk),
    .wr    (ins),
    .waddr (slot_count[SLOT_W-1:0]),
    .wdata (slot_wdata),
    .rd    (slot_rd),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= NB_RESET;
    end else if (cfg_wr_en) begin
      num_buckets <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      slot_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (mode == MODE_CLEAR) begin
              state      <= ST_CLR;
              slot_count <= '0;
            end else if ((mode == MODE_INSERT) || (mode == MODE_LOOKUP)) begin
              state <= ST_HASH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_CLR: begin
          if (!clearing) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_HASH: begin
          if (rem_done) begin
            state <= ST_HCHK;
          end
        end
        ST_HCHK, ST_SCHK: begin
          if (hit || miss) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_SCHK;
          end
          if (ins) begin
            slot_count <= slot_count + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q     <= mode;
      key_q      <= key;
      slot_index <= '0;
      status     <= (mode == MODE_CLEAR) ? STAT_OK : STAT_NF;
    end
    if ((state == ST_HASH) && rem_done) begin
      bucket <= rem;
    end
    if (hit) begin
      slot_index <= slot_raddr_q;
      status     <= (mode_q == MODE_INSERT) ? STAT_DUP : STAT_OK;
    end else if (miss) begin
      if (mode_q == MODE_INSERT) begin
        slot_index <= full ? '0 : slot_count[SLOT_W-1:0];
        status     <= full ? STAT_FULL : STAT_OK;
      end else begin
        slot_index <= '0;
        status     <= STAT_NF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_rd) begin
      slot_raddr_q <= slot_raddr;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    slot_count <= (SLOT_W+1)'(MAX_SLOTS))
    else $error("slot count beyond table size");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_CLEAR)) |=> (busy && clearing))
    else $error("clear transaction did not start sweep");

  a_no_walk_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_HCHK) || (state == ST_SCHK)) |-> !clearing)
    else $error("chain walk during head sweep");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_FULL)) |-> (slot_index == '0))
    else $error("full result carries a slot");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import chim_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [1:0]        st;
  } answer_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        mode;
  logic [KEY_W-1:0]  key;
  logic              cfg_wr_en;
  logic [NB_W-1:0]   cfg_wr_data;
  logic              done;
  logic [SLOT_W-1:0] slot_index;
  logic [1:0]        status;

  // shadow copy of the map
  logic              head_ok [MAX_BUCKETS];
  logic [SLOT_W-1:0] head_slot [MAX_BUCKETS];
  logic [KEY_W-1:0]  key_store [MAX_SLOTS];
  logic              link_ok [MAX_SLOTS];
  logic [SLOT_W-1:0] link_slot [MAX_SLOTS];
  int                used_slots;
  logic [NB_W-1:0]   bucket_cfg;

  answer_t          due_q[$];
  logic [KEY_W-1:0] key_pool[$];
  int               fails;
  int               sent;
  int               checked;
  int               cycles;
  int               n_clear;
  int               n_full;
  int               n_dup;
  int               n_miss;
  bit               burst;

  chained_hash_index_map u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key         (key),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .slot_index  (slot_index),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int bucket_for(logic [KEY_W-1:0] k);
    int nb;
    nb = bucket_cfg;
    if (nb == 0) nb = 1;
    if (nb > MAX_BUCKETS) nb = MAX_BUCKETS;
    return int'(k % nb);
  endfunction

  function automatic bit locate_key(logic [KEY_W-1:0] k, output logic [SLOT_W-1:0] where);
    int b;
    int steps;
    logic ok;
    logic [SLOT_W-1:0] cur;
    b = bucket_for(k);
    ok = head_ok[b];
    cur = head_slot[b];
    steps = 0;
    where = '0;
    while (ok && steps < MAX_SLOTS) begin
      if (key_store[cur] == k) begin
        where = cur;
        return 1'b1;
      end
      ok = link_ok[cur];
      cur = link_slot[cur];
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic void wipe_heads();
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      head_ok[i] = 1'b0;
      head_slot[i] = '0;
    end
    used_slots = 0;
  endfunction

  function automatic answer_t map_apply(logic [1:0] m, logic [KEY_W-1:0] k);
    answer_t a;
    logic [SLOT_W-1:0] hit;
    int b;
    a.slot = '0;
    a.st = STAT_NF;
    case (m)
      MODE_CLEAR: begin
        wipe_heads();
        a.st = STAT_OK;
        n_clear++;
      end
      MODE_INSERT: begin
        if (locate_key(k, hit)) begin
          a.slot = hit;
          a.st = STAT_DUP;
          n_dup++;
        end else if (used_slots >= MAX_SLOTS) begin
          a.st = STAT_FULL;
          n_full++;
        end else begin
          b = bucket_for(k);
          key_store[used_slots] = k;
          link_slot[used_slots] = head_slot[b];
          link_ok[used_slots] = head_ok[b];
          head_slot[b] = used_slots[SLOT_W-1:0];
          head_ok[b] = 1'b1;
          a.slot = used_slots[SLOT_W-1:0];
          a.st = STAT_OK;
          used_slots++;
          key_pool.push_back(k);
        end
      end
      MODE_LOOKUP: begin
        if (locate_key(k, hit)) begin
          a.slot = hit;
          a.st = STAT_OK;
        end else begin
          n_miss++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // one transaction; start stays high across back-to-back items
  task automatic send_item(logic [1:0] m, logic [KEY_W-1:0] k);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    key <= k;
    do @(posedge clk); while (busy);
    due_q.push_back(map_apply(m, k));
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_buckets(logic [NB_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bucket_cfg = v;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_q.size() == 0) begin
        $display("%0t unexpected transaction: slot %0d status %0d", $time, slot_index, status);
        fails++;
      end else begin
        answer_t e;
        e = due_q.pop_front();
        checked++;
        if (slot_index !== e.slot) begin
          $display("%0t slot_index mismatch: expected %0d actual %0d", $time, e.slot, slot_index);
          fails++;
        end
        if (status !== e.st) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, e.st, status);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL chained_hash_index_map");
      $finish;
    end
  end

  task automatic test_basic();
    send_item(MODE_CLEAR, 32'd0);
    send_item(MODE_INSERT, 32'd0);
    send_item(MODE_INSERT, 32'hFFFF_FFFF);
    send_item(MODE_INSERT, 32'd0);
    send_item(MODE_LOOKUP, 32'hFFFF_FFFF);
    send_item(MODE_LOOKUP, 32'd5);
    send_item(2'd3, 32'd0);
    send_item(2'd3, 32'hFFFF_FFFF);
  endtask

  task automatic test_bucket_range();
    set_buckets(12'd1);
    send_item(MODE_INSERT, 32'd7);
    send_item(MODE_INSERT, 32'd8);
    send_item(MODE_INSERT, 32'hA5A5_5A5A);
    send_item(MODE_LOOKUP, 32'd0);
    send_item(MODE_INSERT, 32'd8);
    set_buckets(12'd0);
    send_item(MODE_LOOKUP, 32'd7);
    set_buckets(12'd4095);
    send_item(MODE_LOOKUP, 32'hFFFF_FFFF);
    send_item(MODE_INSERT, 32'd2048);
    send_item(MODE_INSERT, 32'd4096);
    set_buckets(12'd2048);
    send_item(MODE_LOOKUP, 32'd4096);
    send_item(MODE_LOOKUP, 32'd8);
  endtask

  task automatic test_full_table();
    set_buckets(12'd2039);
    send_item(MODE_CLEAR, 32'd0);
    burst = 1'b1;
    for (int i = 0; i < MAX_SLOTS; i++) send_item(MODE_INSERT, $urandom());
    burst = 1'b0;
    send_item(MODE_INSERT, 32'h1234_5679);
    send_item(MODE_INSERT, key_pool[key_pool.size() - 1]);
    send_item(MODE_LOOKUP, key_pool[key_pool.size() - 1]);
    send_item(MODE_LOOKUP, key_pool[key_pool.size() / 2]);
    send_item(MODE_CLEAR, 32'd0);
    send_item(MODE_LOOKUP, key_pool[3]);
  endtask

  task automatic test_random_mix();
    logic [NB_W-1:0] nbs [10];
    logic [1:0]      m;
    logic [KEY_W-1:0] k;
    int              r;
    nbs = '{12'd1, 12'd2, 12'd7, 12'd2048, 12'd4095, 12'd0, 12'd13, 12'd2039, 12'd3000, 12'd0};
    nbs[9] = $urandom_range(1, 4095);
    for (int ph = 0; ph < 10; ph++) begin
      set_buckets(nbs[ph]);
      if (ph % 2 == 0 || used_slots > 600) begin
        key_pool.delete();
        send_item(MODE_CLEAR, $urandom());
      end
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(0, 19) == 0) burst = ~burst;
        if ($urandom_range(0, 59) == 0) drain();
        r = $urandom_range(0, 99);
        if (r < 48) m = MODE_INSERT;
        else if (r < 90) m = MODE_LOOKUP;
        else if (r < 97) m = 2'd3;
        else m = MODE_CLEAR;
        r = $urandom_range(0, 9);
        if (r < 5 && key_pool.size() != 0)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 7)
          k = $urandom_range(0, 63);
        else
          k = $urandom();
        send_item(m, k);
      end
      burst = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_CLEAR;
    key = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = NB_RESET;
    bucket_cfg = NB_RESET;
    fails = 0;
    sent = 0;
    checked = 0;
    cycles = 0;
    n_clear = 0;
    n_full = 0;
    n_dup = 0;
    n_miss = 0;
    burst = 1'b0;
    wipe_heads();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_basic();
    test_bucket_range();
    test_full_table();
    test_random_mix();

    drain();
    repeat (50) @(posedge clk);
    $display("%0d transactions sent, %0d results checked, %0d mismatches", sent, checked, fails);
    $display("clears %0d, duplicates %0d, full inserts %0d, misses %0d", n_clear, n_dup,
             n_full, n_miss);
    if (fails == 0 && due_q.size() == 0) begin
      $display("PASS chained_hash_index_map");
    end else begin
      $display("FAIL chained_hash_index_map");
    end
    $finish;
  end

endmodule

[chained_hash_index_map.f]
sv/chim_pkg.sv
sv/chim_rem.sv
sv/chim_heads.sv
sv/chim_slots.sv
sv/chained_hash_index_map.sv
tb/testbench.sv
